// File: rtl/shell_argument_splitter_assert.svh
// Assertion macros shared by the argument splitter RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SHELL_ARGUMENT_SPLITTER_ASSERT_SVH
`define SHELL_ARGUMENT_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Types, codes and constants shared by the argument splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_SPACES = 3'd0,
    MODE_ARG    = 3'd1,
    MODE_SQ     = 3'd2,
    MODE_DQ     = 3'd3,
    MODE_ESC    = 3'd4,
    MODE_DQESC  = 3'd5
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ENDARG = 2'd1,
    KIND_OK     = 2'd2,
    KIND_ERR    = 2'd3
  } kind_t;

  // Special bytes
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Command queue geometry; depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last_of_run;
  } out_item_t;

  // One classified input item: one or two results
  typedef struct packed {
    logic [7:0] byte0;
    kind_t      kind0;
    logic [7:0] byte1;
    kind_t      kind1;
    logic       two;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SP) || (ch == CH_NL) || (ch == CH_TAB);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sas_front.sv
// ----------------------------------------------------------------------------
// sas_front
// Parser front end: tracks the parse mode and turns each byte into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sas_pkg::in_item_t   in_data,
  input  sas_pkg::q_status_t  q_status,
  output logic                push,
  output sas_pkg::cmd_t       push_cmd
);

  sas_pkg::mode_t mode_r;
  sas_pkg::mode_t mode_nxt;
  logic           in_fire;
  logic           has_res;
  logic [7:0]     ch;

  assign in_stall = q_status.full;
  assign in_fire  = in_valid && !in_stall;
  assign ch       = in_data.char_byte;
  assign push     = in_fire && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sas_pkg::MODE_SPACES;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    has_res        = 1'b0;
    push_cmd.byte0 = 8'd0;
    push_cmd.kind0 = sas_pkg::KIND_BYTE;
    push_cmd.byte1 = 8'd0;
    push_cmd.kind1 = sas_pkg::KIND_BYTE;
    push_cmd.two   = 1'b0;
    if (in_fire) begin
      if (in_data.end_marker) begin
        has_res  = 1'b1;
        mode_nxt = sas_pkg::MODE_SPACES;
        case (mode_r)
          sas_pkg::MODE_ARG: begin
            push_cmd.kind0 = sas_pkg::KIND_ENDARG;
            push_cmd.kind1 = sas_pkg::KIND_OK;
            push_cmd.two   = 1'b1;
          end
          sas_pkg::MODE_SPACES: begin
            push_cmd.kind0 = sas_pkg::KIND_OK;
          end
          default: begin
            push_cmd.kind0 = sas_pkg::KIND_ERR;
          end
        endcase
      end else begin
        case (mode_r)
          sas_pkg::MODE_SQ: begin
            if (ch == sas_pkg::CH_SQ) begin
              mode_nxt = sas_pkg::MODE_ARG;
            end else begin
              has_res        = 1'b1;
              push_cmd.byte0 = ch;
            end
          end
          sas_pkg::MODE_DQ: begin
            if (ch == sas_pkg::CH_DQ) begin
              mode_nxt = sas_pkg::MODE_ARG;
            end else if (ch == sas_pkg::CH_BS) begin
              mode_nxt = sas_pkg::MODE_DQESC;
            end else begin
              has_res        = 1'b1;
              push_cmd.byte0 = ch;
            end
          end
          sas_pkg::MODE_ESC: begin
            has_res        = 1'b1;
            push_cmd.byte0 = ch;
            mode_nxt       = sas_pkg::MODE_ARG;
          end
          sas_pkg::MODE_DQESC: begin
            has_res  = 1'b1;
            mode_nxt = sas_pkg::MODE_DQ;
            if (ch != sas_pkg::CH_DQ && ch != sas_pkg::CH_BS) begin
              // keep the backslash, then the byte
              push_cmd.byte0 = sas_pkg::CH_BS;
              push_cmd.byte1 = ch;
              push_cmd.two   = 1'b1;
            end else begin
              push_cmd.byte0 = ch;
            end
          end
          default: begin
            if (ch == sas_pkg::CH_DQ) begin
              mode_nxt = sas_pkg::MODE_DQ;
            end else if (ch == sas_pkg::CH_SQ) begin
              mode_nxt = sas_pkg::MODE_SQ;
            end else if (ch == sas_pkg::CH_BS) begin
              mode_nxt = sas_pkg::MODE_ESC;
            end else if (sas_pkg::is_blank(ch)) begin
              if (mode_r == sas_pkg::MODE_ARG) begin
                has_res        = 1'b1;
                push_cmd.kind0 = sas_pkg::KIND_ENDARG;
              end
              mode_nxt = sas_pkg::MODE_SPACES;
            end else begin
              has_res        = 1'b1;
              push_cmd.byte0 = ch;
              mode_nxt       = sas_pkg::MODE_ARG;
            end
          end
        endcase
      end
    end
  end

`include "shell_argument_splitter_assert.svh"

  `SAS_ASSERT_NEXT(a_end_resets_mode, in_fire && in_data.end_marker, mode_r == sas_pkg::MODE_SPACES, "mode not back to spaces after end marker")

endmodule

`default_nettype wire

// File: rtl/sas_queue.sv
// ----------------------------------------------------------------------------
// sas_queue
// Short command queue between the parser front end and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  sas_pkg::cmd_t       push_cmd,
  input  wire                 pop,
  output sas_pkg::cmd_t       head_cmd,
  output sas_pkg::q_status_t  q_status
);

  sas_pkg::cmd_t                 slot_r [sas_pkg::QDEPTH];
  logic [sas_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [sas_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [sas_pkg::QCNT_W-1:0]    count_r;
  logic [sas_pkg::QCNT_W-1:0]    count_nxt;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == sas_pkg::QCNT_W'(sas_pkg::QDEPTH));
  assign head_cmd       = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`include "shell_argument_splitter_assert.svh"

  `SAS_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "pop from empty command queue")
  `SAS_ASSERT_NOW(a_no_overflow, push, !q_status.full, "push into full command queue")

endmodule

`default_nettype wire

// File: rtl/sas_back.sv
// ----------------------------------------------------------------------------
// sas_back
// Result emitter: unpacks queued commands into results on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sas_pkg::cmd_t       head_cmd,
  input  sas_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output sas_pkg::out_item_t  out_data
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  sas_pkg::out_item_t  out_data_r;
  sas_pkg::out_item_t  out_data_nxt;
  logic                phase_r;
  logic                phase_nxt;
  logic                slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (phase_r) begin
        // second result of a two-result command
        out_data_nxt.out_byte    = head_cmd.byte1;
        out_data_nxt.kind        = head_cmd.kind1;
        out_data_nxt.last_of_run = 1'b1;
        out_valid_nxt            = 1'b1;
        phase_nxt                = 1'b0;
        pop                      = 1'b1;
      end else if (!q_status.empty) begin
        out_data_nxt.out_byte    = head_cmd.byte0;
        out_data_nxt.kind        = head_cmd.kind0;
        out_data_nxt.last_of_run = !head_cmd.two;
        out_valid_nxt            = 1'b1;
        phase_nxt                = head_cmd.two;
        pop                      = !head_cmd.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`include "shell_argument_splitter_assert.svh"

  `SAS_ASSERT_NOW(a_phase_has_head, phase_r, !q_status.empty, "second result pending with empty queue")

endmodule

`default_nettype wire

// File: rtl/shell_argument_splitter.sv
// ----------------------------------------------------------------------------
// shell_argument_splitter
// Streaming shell-style splitter of a command line into arguments.
// ----------------------------------------------------------------------------
// Feed one command-line byte per transfer on the in_ channel, and close each
// line with a transfer that has end_marker set. Results come out on the out_
// channel: argument bytes (kind 0), end of argument (kind 1), line done ok
// (kind 2) or parse error (kind 3, line ended inside a quote or an escape);
// last_of_run flags the final result caused by one input transfer. A blank
// while skipping blanks, opening/closing quotes and escape backslashes cause
// no result; a blank that closes an argument yields end of argument. The
// block takes one byte per cycle unless the command queue is full; an input
// transfer that yields two results (a kept backslash inside double quotes,
// or end of argument plus line done) makes two output transfers, and a
// four-entry command queue between parser and emitter absorbs that so input
// keeps flowing. Each result is registered in the queue and then in the
// output register. After reset the parser skips blanks and is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_argument_splitter (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sas_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sas_pkg::out_item_t  out_data
);

  sas_pkg::cmd_t       push_cmd;
  sas_pkg::cmd_t       head_cmd;
  sas_pkg::q_status_t  q_status;
  logic                push;
  logic                pop;

  // Parse mode tracking; classify each byte into a command
  sas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Hold commands so that parser and emitter stall independently
  sas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  // Drain commands one result per output transfer
  sas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sim/shell_argument_splitter_checker.sv
// ----------------------------------------------------------------------------
// shell_argument_splitter_checker
// Watches both channels of the argument splitter, predicts the result stream
// from the accepted input bytes and compares it in order, field by field.
// ----------------------------------------------------------------------------

module shell_argument_splitter_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sas_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sas_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked
);

  import sas_pkg::*;

  localparam int PRINT_CAP = 40;

  mode_t     split_mode = MODE_SPACES;
  out_item_t split_results_q[$];
  int        err_total  = 0;
  int        seen_total = 0;

  function automatic void queue_result(input logic [7:0] b, input kind_t k);
    out_item_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.last_of_run = 1'b0;
    split_results_q.insert(split_results_q.size(), r);
  endfunction

  // Advance the parse mode by one accepted byte and queue what it yields.
  function automatic void predict_split(input in_item_t item);
    int         base;
    mode_t      m;
    logic [7:0] ch;
    out_item_t  tail;
    base = split_results_q.size();
    m    = split_mode;
    ch   = item.char_byte;
    if (item.end_marker) begin
      if (m == MODE_ARG) begin
        queue_result(8'h00, KIND_ENDARG);
        queue_result(8'h00, KIND_OK);
      end else if (m == MODE_SPACES) begin
        queue_result(8'h00, KIND_OK);
      end else begin
        queue_result(8'h00, KIND_ERR);
      end
      m = MODE_SPACES;
    end else begin
      case (m)
        MODE_SQ: begin
          if (ch == CH_SQ) m = MODE_ARG;
          else queue_result(ch, KIND_BYTE);
        end
        MODE_DQ: begin
          if (ch == CH_DQ) m = MODE_ARG;
          else if (ch == CH_BS) m = MODE_DQESC;
          else queue_result(ch, KIND_BYTE);
        end
        MODE_ESC: begin
          queue_result(ch, KIND_BYTE);
          m = MODE_ARG;
        end
        MODE_DQESC: begin
          // keep the backslash unless it escapes a quote or a backslash
          if (ch != CH_DQ && ch != CH_BS) queue_result(CH_BS, KIND_BYTE);
          queue_result(ch, KIND_BYTE);
          m = MODE_DQ;
        end
        default: begin
          if (ch == CH_DQ) begin
            m = MODE_DQ;
          end else if (ch == CH_SQ) begin
            m = MODE_SQ;
          end else if (ch == CH_BS) begin
            m = MODE_ESC;
          end else if (ch == CH_SP || ch == CH_NL || ch == CH_TAB) begin
            if (m == MODE_ARG) queue_result(8'h00, KIND_ENDARG);
            m = MODE_SPACES;
          end else begin
            queue_result(ch, KIND_BYTE);
            m = MODE_ARG;
          end
        end
      endcase
    end
    if (split_results_q.size() > base) begin
      tail = split_results_q.pop_back();
      tail.last_of_run = 1'b1;
      split_results_q.insert(split_results_q.size(), tail);
    end
    split_mode = m;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      split_mode = MODE_SPACES;
      split_results_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_split(in_data);
      if (out_valid && !out_stall) begin
        seen_total++;
        if (split_results_q.size() == 0) begin
          err_total++;
          if (err_total <= PRINT_CAP)
            $display("%0t: result %0d unexpected: expected none, got byte=%02h kind=%0d last=%0b",
                     $time, seen_total, out_data.out_byte, out_data.kind,
                     out_data.last_of_run);
        end else begin
          want = split_results_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind ||
              out_data.last_of_run !== want.last_of_run) begin
            err_total++;
            if (err_total <= PRINT_CAP)
              $display("%0t: result %0d: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                       $time, seen_total, want.out_byte, want.kind, want.last_of_run,
                       out_data.out_byte, out_data.kind, out_data.last_of_run);
          end
        end
      end
    end
    mismatches      <= err_total;
    outstanding     <= split_results_q.size();
    results_checked <= seen_total;
  end

endmodule

// File: sim/tb_shell_argument_splitter.sv
// ----------------------------------------------------------------------------
// tb_shell_argument_splitter
// Feeds command lines through the argument splitter under random gaps and
// output stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------

module tb_shell_argument_splitter;

  import sas_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int STALL_LIMIT    = 1000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 12;    // extra wait once no results are outstanding

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int results_checked;

  int items_sent     = 0;
  int lines_sent     = 0;
  int directed_items = 0;
  int burst_left     = 0;

  shell_argument_splitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  shell_argument_splitter_checker i_split_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length for either side: mostly none, sometimes a few cycles,
  // now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte that is neither a quote, a backslash nor a blank.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_DQ || b == CH_SQ || b == CH_BS ||
           b == CH_SP || b == CH_NL || b == CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0:       return CH_SP;
      1:       return CH_NL;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 5))
      0:       return CH_DQ;
      1:       return CH_SQ;
      2:       return CH_BS;
      3:       return CH_SP;
      4:       return CH_NL;
      default: return CH_TAB;
    endcase
  endfunction

  // Present one item and hold it until the block takes it. The gap before it
  // drops valid for a while, except inside a gap-free burst.
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 4) burst_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (item.end_marker) lines_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item('{char_byte: ch, end_marker: 1'b0});
  endtask

  // The byte carried with an end marker is don't-care; randomize it anyway.
  task automatic send_end(input logic [7:0] ch);
    send_item('{char_byte: ch, end_marker: 1'b1});
  endtask

  // One well-formed command line: words built from plain runs, quoted
  // segments and escapes, separated by blank runs, closed by an end marker.
  task automatic send_line();
    int         words;
    int         segs;
    int         len;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) send_char(blank_byte());
    words = $urandom_range(0, 4);
    for (int w = 0; w < words; w++) begin
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
        len = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
          0: begin
            repeat (len + 1) send_char(plain_byte());
          end
          1: begin
            // single quotes: anything but the closing quote, blanks included
            send_char(CH_SQ);
            repeat (len) begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_SQ);
              send_char(b);
            end
            send_char(CH_SQ);
          end
          2: begin
            // double quotes: mix literal bytes with escapes, favoring the
            // escaped quote and backslash that drop the backslash
            send_char(CH_DQ);
            repeat (len) begin
              if ($urandom_range(0, 2) == 0) begin
                send_char(CH_BS);
                if ($urandom_range(0, 1)) send_char(8'($urandom_range(0, 255)));
                else send_char($urandom_range(0, 1) ? CH_DQ : CH_BS);
              end else begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_DQ || b == CH_BS);
                send_char(b);
              end
            end
            send_char(CH_DQ);
          end
          default: begin
            send_char(CH_BS);
            send_char(8'($urandom_range(0, 255)));
          end
        endcase
      end
      // the last word may run straight into the end marker
      if (w < words - 1 || $urandom_range(0, 1))
        repeat ($urandom_range(1, 2)) send_char(blank_byte());
    end
    send_end(8'($urandom_range(0, 255)));
  endtask

  // Noise: random bytes heavy on quotes, escapes and blanks, stray end
  // markers, often a line left open inside a quote or escape.
  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_char(special_byte());
        9:       send_end(8'($urandom_range(0, 255)));
        default: send_char(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 9) < 7) send_end(8'($urandom_range(0, 255)));
  endtask

  // Result side stall: random stalls, with long stall-free windows now and then.
  initial begin : result_backpressure
    int n;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results still expected",
             $time, STALL_LIMIT, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme bytes, blank kinds, closing an argument by blank and
    // by end marker, end while skipping.
    send_char(CH_SP);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_TAB);
    send_end(8'hA5);
    // empty quoted argument closed by a newline
    send_char(CH_DQ);
    send_char(CH_DQ);
    send_char(CH_NL);
    // single quotes keep a backslash literally
    send_char(CH_SQ);
    send_char(CH_BS);
    send_char(CH_SQ);
    // double quotes: kept backslash, escaped quote, then close
    send_char(CH_DQ);
    send_char(CH_BS);
    send_char("n");
    send_char(CH_BS);
    send_char(CH_DQ);
    send_char(CH_DQ);
    // escaped blank outside quotes, then end in argument
    send_char(CH_BS);
    send_char(CH_SP);
    send_end(8'h5A);
    // lines that end inside a single quote, an escape, an escape in quotes
    send_char(CH_SQ);
    send_end(8'hFF);
    send_char(CH_BS);
    send_end(8'h00);
    send_char(CH_DQ);
    send_char(CH_BS);
    send_end(8'hC3);
    directed_items = items_sent;

    // Random: mostly well-formed lines, the rest noise.
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) send_line();
      else send_noise();
    end
    in_valid <= 1'b0;

    // let the checker see the last transfer, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and end markers (%0d directed) in %0d command lines",
             items_sent, directed_items, lines_sent);
    $display("Compared %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
